FILE: sv/kwa_pkg.sv
package kwa_pkg;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [31:0] sample_ms;
        logic [31:0] frame_ms;
        logic [31:0] window_ms;
    } req_t;

    typedef struct packed {
        logic [31:0] average_ms;
        logic        found;
        logic        dropped;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_CMP,
        S_META_RD,
        S_META,
        S_STORE,
        S_AVG_INIT,
        S_W_RD,
        S_W_ACC,
        S_W_ADD,
        S_W_CHK,
        S_DIV,
        S_RESP
    } state_t;

endpackage

FILE: sv/keyed_time_weighted_window_average.sv
// Keyed time-weighted window average.
// Channels: req (valid/ready) carries one command word: push a sample,
// query a key's average, or clear the table. rsp (valid/ready) returns one
// word per command with average_ms, found and dropped.
// One command at a time: req_ready is high only while the sequencer idles.
// Steps per command: accept, then a linear search over used slots
// (read and compare a key per slot), fetch the ring state, store a pushed
// sample, start the walk, walk the history entries (RAM read, multiply,
// accumulate, check; a zero-duration entry skips the accumulate), run the
// 64-step bit-serial divide, and load the response. Clear and unused kinds
// go straight to the response.
// Reset empties the table (no slots used); no memory sweep is needed since
// a slot's ring state is rewritten when the slot is allocated.
// When rsp stalls, the finished word waits in the output register; the
// next command is accepted meanwhile and holds in its last state until the
// output register frees up.
module keyed_time_weighted_window_average #(
    parameter int NUM_SLOTS     = 32,
    parameter int HISTORY_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  kwa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output kwa_pkg::rsp_t rsp
);

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SU_W    = $clog2(NUM_SLOTS + 1);
    localparam int POS_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int HIST_N  = NUM_SLOTS * HISTORY_DEPTH;
    localparam int HADDR_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int META_W  = POS_W + CNT_W;

    localparam logic [SU_W-1:0]    SLOTS_MAX = SU_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W:0]     DEPTH_EXT = (CNT_W + 1)'(HISTORY_DEPTH);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(HISTORY_DEPTH - 1);
    localparam logic [HADDR_W-1:0] DEPTH_H   = HADDR_W'(HISTORY_DEPTH);

    kwa_pkg::state_t state_reg, state_next;

    kwa_pkg::req_t      cmd_reg, cmd_next;
    logic [SU_W-1:0]    used_reg, used_next;
    logic [SU_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   age_reg, age_next;
    logic [63:0]        sum_reg, sum_next;
    logic [31:0]        cov_reg, cov_next;
    logic [31:0]        take_reg, take_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        newest_reg, newest_next;
    kwa_pkg::rsp_t      res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    kwa_pkg::rsp_t      rsp_reg, rsp_next;

    // memories
    logic               key_we;
    logic [15:0]        key_rdata;
    logic               meta_we;
    logic [META_W-1:0]  meta_wdata, meta_rdata;
    logic               hist_we;
    logic [HADDR_W-1:0] hist_waddr, hist_raddr;
    logic [63:0]        hist_rdata;

    // divider
    logic        div_start, div_done;
    logic [31:0] div_quo;

    // helpers
    logic [CNT_W:0]  wr_sum, nw_sum;
    logic [POS_W-1:0] wr_pos, nw_pos, ptr_dec;
    logic [31:0]      h_val, h_dur, w_rem, w_take;
    logic             key_hit, out_free;

    assign h_val   = hist_rdata[63:32];
    assign h_dur   = hist_rdata[31:0];
    assign key_hit = (key_rdata == cmd_reg.key);
    assign out_free = !rsp_valid_reg || rsp_ready;

    kwa_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_next),
        .wdata (cmd_reg.key),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (key_rdata)
    );

    kwa_ram #(.WIDTH(META_W), .DEPTH(NUM_SLOTS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wdata),
        .raddr (slot_reg),
        .rdata (meta_rdata)
    );

    kwa_ram #(.WIDTH(64), .DEPTH(HIST_N)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata ({cmd_reg.sample_ms, cmd_reg.frame_ms}),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    kwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cov_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ring arithmetic: write position, newest position, walk pointer step
    always_comb
    begin
        wr_sum  = (CNT_W + 1)'(start_reg) + (CNT_W + 1)'(cnt_reg);
        if (wr_sum >= DEPTH_EXT)
        begin
            wr_sum = wr_sum - DEPTH_EXT;
        end
        wr_pos  = wr_sum[POS_W-1:0];
        nw_sum  = (CNT_W + 1)'(start_reg) + (CNT_W + 1)'(cnt_reg) - (CNT_W + 1)'(1);
        if (nw_sum >= DEPTH_EXT)
        begin
            nw_sum = nw_sum - DEPTH_EXT;
        end
        nw_pos  = nw_sum[POS_W-1:0];
        ptr_dec = (ptr_reg == '0) ? POS_LAST : ptr_reg - POS_W'(1);
        w_rem   = cmd_reg.window_ms - cov_reg;
        w_take  = (h_dur < w_rem) ? h_dur : w_rem;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kwa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.kind == kwa_pkg::KIND_PUSH || req.kind == kwa_pkg::KIND_QUERY)
                    begin
                        state_next = kwa_pkg::S_KEY_RD;
                    end
                    else
                    begin
                        state_next = kwa_pkg::S_RESP;
                    end
                end
            end
            kwa_pkg::S_KEY_RD:
            begin
                if (idx_reg != used_reg)
                begin
                    state_next = kwa_pkg::S_KEY_CMP;
                end
                else if (cmd_reg.kind == kwa_pkg::KIND_PUSH && used_reg != SLOTS_MAX)
                begin
                    state_next = kwa_pkg::S_STORE;
                end
                else
                begin
                    state_next = kwa_pkg::S_RESP;
                end
            end
            kwa_pkg::S_KEY_CMP:
            begin
                state_next = key_hit ? kwa_pkg::S_META_RD : kwa_pkg::S_KEY_RD;
            end
            kwa_pkg::S_META_RD:  state_next = kwa_pkg::S_META;
            kwa_pkg::S_META:
            begin
                state_next = (cmd_reg.kind == kwa_pkg::KIND_PUSH) ? kwa_pkg::S_STORE
                                                                 : kwa_pkg::S_AVG_INIT;
            end
            kwa_pkg::S_STORE:    state_next = kwa_pkg::S_AVG_INIT;
            kwa_pkg::S_AVG_INIT:
            begin
                state_next = (cnt_reg == '0) ? kwa_pkg::S_RESP : kwa_pkg::S_W_RD;
            end
            kwa_pkg::S_W_RD:     state_next = kwa_pkg::S_W_ACC;
            kwa_pkg::S_W_ACC:
            begin
                if (cmd_reg.window_ms == '0)
                begin
                    state_next = kwa_pkg::S_RESP;
                end
                else if (h_dur == '0)
                begin
                    state_next = kwa_pkg::S_W_CHK;
                end
                else
                begin
                    state_next = kwa_pkg::S_W_ADD;
                end
            end
            kwa_pkg::S_W_ADD:    state_next = kwa_pkg::S_W_CHK;
            kwa_pkg::S_W_CHK:
            begin
                if (age_reg < cnt_reg && cov_reg < cmd_reg.window_ms)
                begin
                    state_next = kwa_pkg::S_W_RD;
                end
                else if (cov_reg == '0)
                begin
                    state_next = kwa_pkg::S_RESP;
                end
                else
                begin
                    state_next = kwa_pkg::S_DIV;
                end
            end
            kwa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = kwa_pkg::S_RESP;
                end
            end
            kwa_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = kwa_pkg::S_IDLE;
                end
            end
            default:             state_next = kwa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        age_next       = age_reg;
        sum_next       = sum_reg;
        cov_next       = cov_reg;
        take_next      = take_reg;
        prod_next      = prod_reg;
        newest_next    = newest_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        key_we         = 1'b0;
        meta_we        = 1'b0;
        hist_we        = 1'b0;
        div_start      = 1'b0;
        meta_wdata     = {start_reg, cnt_reg};
        hist_waddr     = HADDR_W'(slot_reg) * DEPTH_H + HADDR_W'(wr_pos);
        hist_raddr     = HADDR_W'(slot_reg) * DEPTH_H + HADDR_W'(ptr_reg);

        // drain the output register whenever the receiver takes the word
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            kwa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                idx_next  = '0;
                res_next  = '0;
                if (req_valid)
                begin
                    cmd_next = req;
                    if (req.kind == kwa_pkg::KIND_CLEAR)
                    begin
                        used_next = '0;
                    end
                end
            end
            kwa_pkg::S_KEY_RD:
            begin
                if (idx_reg == used_reg && cmd_reg.kind == kwa_pkg::KIND_PUSH)
                begin
                    if (used_reg == SLOTS_MAX)
                    begin
                        res_next.dropped = 1'b1;
                    end
                    else
                    begin
                        // allocate the next free slot with an empty ring
                        slot_next  = used_reg[SLOT_W-1:0];
                        key_we     = 1'b1;
                        used_next  = used_reg + SU_W'(1);
                        start_next = '0;
                        cnt_next   = '0;
                    end
                end
            end
            kwa_pkg::S_KEY_CMP:
            begin
                if (key_hit)
                begin
                    slot_next = idx_reg[SLOT_W-1:0];
                end
                else
                begin
                    idx_next = idx_reg + SU_W'(1);
                end
            end
            kwa_pkg::S_META_RD:
            begin
            end
            kwa_pkg::S_META:
            begin
                start_next = meta_rdata[META_W-1:CNT_W];
                cnt_next   = meta_rdata[CNT_W-1:0];
            end
            kwa_pkg::S_STORE:
            begin
                hist_we = 1'b1;
                meta_we = 1'b1;
                if (cnt_reg < DEPTH_CNT)
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    meta_wdata = {start_reg, cnt_next};
                end
                else
                begin
                    // full ring: overwrite the oldest, advance start
                    hist_waddr = HADDR_W'(slot_reg) * DEPTH_H + HADDR_W'(start_reg);
                    start_next = (start_reg == POS_LAST) ? '0 : start_reg + POS_W'(1);
                    meta_wdata = {start_next, cnt_reg};
                end
            end
            kwa_pkg::S_AVG_INIT:
            begin
                res_next.found = 1'b1;
                ptr_next       = nw_pos;
                age_next       = '0;
                sum_next       = '0;
                cov_next       = '0;
            end
            kwa_pkg::S_W_RD:
            begin
            end
            kwa_pkg::S_W_ACC:
            begin
                if (age_reg == '0)
                begin
                    newest_next = h_val;
                end
                if (cmd_reg.window_ms == '0)
                begin
                    res_next.average_ms = h_val;
                end
                else if (h_dur == '0)
                begin
                    age_next = age_reg + CNT_W'(1);
                    ptr_next = ptr_dec;
                end
                else
                begin
                    take_next = w_take;
                    prod_next = 64'(h_val) * 64'(w_take);
                end
            end
            kwa_pkg::S_W_ADD:
            begin
                sum_next = sum_reg + prod_reg;
                cov_next = cov_reg + take_reg;
                age_next = age_reg + CNT_W'(1);
                ptr_next = ptr_dec;
            end
            kwa_pkg::S_W_CHK:
            begin
                if (!(age_reg < cnt_reg && cov_reg < cmd_reg.window_ms))
                begin
                    if (cov_reg == '0)
                    begin
                        res_next.average_ms = newest_reg;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            kwa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    res_next.average_ms = div_quo;
                end
            end
            kwa_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kwa_pkg::S_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        start_reg  <= start_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        age_reg    <= age_next;
        sum_reg    <= sum_next;
        cov_reg    <= cov_next;
        take_reg   <= take_next;
        prod_reg   <= prod_next;
        newest_reg <= newest_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/kwa_ram.sv
module kwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/kwa_div.sv
module kwa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  step_reg, step_next;
    logic [32:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] shifted;

    // one restoring step per cycle, dividend bits shift out as quotient bits shift in
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        done      = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 6'd0;
            rem_next  = 33'd0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = quo_next[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
    end

endmodule

FILE: tb/sv/tb.sv
module tb;

    localparam int SLOT_COUNT  = 32;
    localparam int RING_DEPTH  = 128;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_WORDS = 750;

    // Scoreboard: private copy of the channel table plus the queue of
    // response words still owed by the block.
    class avg_scoreboard;
        logic [15:0] chan_key [SLOT_COUNT];
        int unsigned chan_used;
        int unsigned ring_head [SLOT_COUNT];
        int unsigned ring_fill [SLOT_COUNT];
        logic [31:0] samp_val [SLOT_COUNT][RING_DEPTH];
        logic [31:0] samp_dur [SLOT_COUNT][RING_DEPTH];
        kwa_pkg::rsp_t owed_q[$];
        int          mismatches;

        function new();
            chan_used  = 0;
            mismatches = 0;
            foreach (ring_head[i])
            begin
                ring_head[i] = 0;
                ring_fill[i] = 0;
            end
        endfunction

        function int lookup(logic [15:0] k);
            for (int i = 0; i < chan_used; i++)
                if (chan_key[i] == k)
                    return i;
            return -1;
        endfunction

        function logic [31:0] weighted_avg(int s, logic [31:0] win);
            int unsigned cnt;
            int unsigned p;
            int unsigned newest;
            logic [63:0] acc;
            logic [31:0] covered;
            logic [31:0] d;
            logic [31:0] take;
            cnt = ring_fill[s];
            acc = 0;
            covered = 0;
            if (cnt == 0)
                return 32'd0;
            newest = (ring_head[s] + cnt - 1) % RING_DEPTH;
            if (win == 0)
                return samp_val[s][newest];
            for (int age = 0; age < cnt && covered < win; age++)
            begin
                p = (ring_head[s] + cnt - 1 - age) % RING_DEPTH;
                d = samp_dur[s][p];
                if (d == 0)
                    continue;
                take = (d < win - covered) ? d : win - covered;
                acc += 64'(samp_val[s][p]) * 64'(take);
                covered += take;
            end
            if (covered == 0)
                return samp_val[s][newest];
            return 32'(acc / 64'(covered));
        endfunction

        // Note an accepted command: update the table and queue its answer.
        function void note_command(kwa_pkg::req_t r);
            kwa_pkg::rsp_t e;
            int   s;
            e = '0;
            if (r.kind == kwa_pkg::KIND_PUSH)
            begin
                s = lookup(r.key);
                if (s < 0 && chan_used >= SLOT_COUNT)
                    e.dropped = 1'b1;
                else
                begin
                    if (s < 0)
                    begin
                        s = chan_used;
                        chan_key[s] = r.key;
                        ring_head[s] = 0;
                        ring_fill[s] = 0;
                        chan_used++;
                    end
                    if (ring_fill[s] < RING_DEPTH)
                    begin
                        samp_val[s][(ring_head[s] + ring_fill[s]) % RING_DEPTH] = r.sample_ms;
                        samp_dur[s][(ring_head[s] + ring_fill[s]) % RING_DEPTH] = r.frame_ms;
                        ring_fill[s]++;
                    end
                    else
                    begin
                        samp_val[s][ring_head[s]] = r.sample_ms;
                        samp_dur[s][ring_head[s]] = r.frame_ms;
                        ring_head[s] = (ring_head[s] + 1) % RING_DEPTH;
                    end
                    e.average_ms = weighted_avg(s, r.window_ms);
                    e.found = 1'b1;
                end
            end
            else if (r.kind == kwa_pkg::KIND_QUERY)
            begin
                s = lookup(r.key);
                if (s >= 0)
                begin
                    e.average_ms = weighted_avg(s, r.window_ms);
                    e.found = 1'b1;
                end
            end
            else if (r.kind == kwa_pkg::KIND_CLEAR)
            begin
                chan_used = 0;
                foreach (ring_head[i])
                begin
                    ring_head[i] = 0;
                    ring_fill[i] = 0;
                end
            end
            owed_q.push_back(e);
        endfunction

        // Check one result word against the oldest owed answer.
        function void check_result(kwa_pkg::rsp_t got);
            kwa_pkg::rsp_t e;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word avg=%h found=%b dropped=%b",
                             got.average_ms, got.found, got.dropped);
                return;
            end
            e = owed_q.pop_front();
            if (got.average_ms !== e.average_ms || got.found !== e.found ||
                got.dropped !== e.dropped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp avg=%h found=%b dropped=%b, ",
                              "got avg=%h found=%b dropped=%b"},
                             e.average_ms, e.found, e.dropped,
                             got.average_ms, got.found, got.dropped);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    kwa_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    kwa_pkg::rsp_t rsp;

    avg_scoreboard sb;
    bit quiet_phase;      // no idling in the last part of the run
    bit hold_off;         // request for a long receiver stall
    int idle_cycles;

    keyed_time_weighted_window_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watch accepted words at each edge; count quiet cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_command(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one command word and hold it until accepted, then maybe idle.
    task automatic send_word(kwa_pkg::req_t w);
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_cmd(logic [1:0] k, logic [15:0] key, logic [31:0] v,
                            logic [31:0] d, logic [31:0] w);
        kwa_pkg::req_t r;
        r.kind = k;
        r.key = key;
        r.sample_ms = v;
        r.frame_ms = d;
        r.window_ms = w;
        send_word(r);
    endtask

    // Drop valid and wait until every owed answer has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(1, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // Keys from a small pool so that channels fill up and get revisited.
    function automatic logic [15:0] pool_key();
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 40)) ^ 16'hA5C3;
    endfunction

    task automatic random_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            send_cmd(kwa_pkg::KIND_PUSH, pool_key(), rand_word(), rand_word(), rand_word());
        else if (sel < 94)
            send_cmd(kwa_pkg::KIND_QUERY, pool_key(), rand_word(), rand_word(), rand_word());
        else if (sel < 97)
            send_cmd(kwa_pkg::KIND_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
        else
            send_cmd(kwa_pkg::KIND_UNUSED, 16'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Watchdog on quiet cycles.
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("keyed_time_weighted_window_average test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        quiet_phase = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, zero durations, clip, ring wrap.
        send_cmd(kwa_pkg::KIND_QUERY, 16'h0000, 32'd0, 32'd0, 32'd0);
        send_cmd(kwa_pkg::KIND_PUSH, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(kwa_pkg::KIND_PUSH, 16'hFFFF, 32'h0001_0000, 32'd0, 32'h0002_0000);
        send_cmd(kwa_pkg::KIND_QUERY, 16'hFFFF, 32'd0, 32'd0, 32'd0);
        send_cmd(kwa_pkg::KIND_PUSH, 16'hFFFF, 32'h0003_0000, 32'h0001_8000,
                 32'h0001_0000);
        send_cmd(kwa_pkg::KIND_QUERY, 16'hFFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_cmd(kwa_pkg::KIND_QUERY, 16'h0000, 32'd0, 32'd0, 32'h0000_0001);
        send_cmd(kwa_pkg::KIND_QUERY, 16'h1234, 32'd0, 32'd0, 32'h0001_0000);
        send_cmd(kwa_pkg::KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(kwa_pkg::KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(kwa_pkg::KIND_QUERY, 16'hFFFF, 32'd0, 32'd0, 32'h0001_0000);
        // Fill every slot, then push a new key into the full table.
        for (int i = 0; i < SLOT_COUNT; i++)
            send_cmd(kwa_pkg::KIND_PUSH, 16'(i * 2047), $urandom, $urandom_range(0, 3),
                     $urandom);
        send_cmd(kwa_pkg::KIND_PUSH, 16'hBEEF, 32'h1, 32'h1, 32'h1);
        send_cmd(kwa_pkg::KIND_QUERY, 16'hBEEF, 32'd0, 32'd0, 32'h1);
        // Wrap one channel's ring past its depth.
        for (int i = 0; i < RING_DEPTH + 5; i++)
            send_cmd(kwa_pkg::KIND_PUSH, 16'd0, $urandom, $urandom_range(0, 9),
                     32'($urandom_range(0, 400)));
        send_cmd(kwa_pkg::KIND_QUERY, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);

        // Sender pauses until everything is back.
        drain();
        send_cmd(kwa_pkg::KIND_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);

        // Receiver holds off while the sender keeps offering words.
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            random_cmd();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - 120)
                quiet_phase = 1'b1;
            random_cmd();
        end

        drain();
        repeat (700) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("keyed_time_weighted_window_average test passed");
        else
            $display("keyed_time_weighted_window_average test failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/kwa_pkg.sv
sv/kwa_ram.sv
sv/kwa_div.sv
sv/keyed_time_weighted_window_average.sv
tb/sv/tb.sv
